>>> hdl/rwc_pkg.sv
package rwc_pkg;

  localparam int PIX_W    = 24;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int ACC_W    = 20;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 4;

  localparam logic [1:0] REG_KERNEL_TOP    = 2'd0;
  localparam logic [1:0] REG_KERNEL_MIDDLE = 2'd1;
  localparam logic [1:0] REG_KERNEL_BOTTOM = 2'd2;
  localparam logic [1:0] REG_SCALE         = 2'd3;

  localparam logic [PIX_W-1:0] KERNEL_TOP_RESET    = 24'h000000;
  localparam logic [PIX_W-1:0] KERNEL_MIDDLE_RESET = 24'h000100;
  localparam logic [PIX_W-1:0] KERNEL_BOTTOM_RESET = 24'h000000;
  localparam logic [CH_W-1:0]  SCALE_RESET         = 8'h01;

  localparam logic [CH_W-1:0] CHANNEL_MAX = 8'hFF;

  typedef struct packed {
    logic [PIX_W-1:0] kernel_top;
    logic [PIX_W-1:0] kernel_middle;
    logic [PIX_W-1:0] kernel_bottom;
    logic [CH_W-1:0]  scale;
  } cfg_t;

endpackage

>>> hdl/rwc_pix_in_if.sv
interface rwc_pix_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] in_pixel;
  logic        in_last;
  logic [3:0]  in_keep;
  logic [3:0]  in_strobe;
  logic        in_user;
  logic        in_ident;
  logic        in_route;

  modport source (output valid, in_pixel, in_last, in_keep, in_strobe, in_user, in_ident,
                  in_route, input ready);
  modport sink (input valid, in_pixel, in_last, in_keep, in_strobe, in_user, in_ident,
                in_route, output ready);
endinterface

>>> hdl/rwc_pix_out_if.sv
interface rwc_pix_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] out_pixel;
  logic        out_last;
  logic [3:0]  out_keep;
  logic [3:0]  out_strobe;
  logic        out_user;
  logic        out_ident;
  logic        out_route;

  modport source (output valid, out_pixel, out_last, out_keep, out_strobe, out_user,
                  out_ident, out_route, input ready);
  modport sink (input valid, out_pixel, out_last, out_keep, out_strobe, out_user,
                out_ident, out_route, output ready);
endinterface

>>> hdl/rwc_ram.sv
module rwc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1027
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rwc_div.sv
module rwc_div import rwc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] dividend,
  input  logic signed [CH_W-1:0]  divisor,
  output logic                    done,
  output logic                    neg,
  output logic [ACC_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [CNT_W-1:0] count;
  logic [CH_W-1:0]  dmag;
  logic [CH_W-1:0]  rem;
  logic [CH_W:0]    rem_sh;
  logic [CH_W-1:0]  div_nz;

  assign div_nz = (divisor == '0) ? CH_W'(1) : divisor;
  assign rem_sh = {rem, quotient[ACC_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= CNT_W'(ACC_W);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - CNT_W'(1);
      done  <= (count == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg      <= dividend[ACC_W-1] ^ div_nz[CH_W-1];
      quotient <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      dmag     <= div_nz[CH_W-1] ? CH_W'(-div_nz) : div_nz;
      rem      <= '0;
    end else if (count != '0) begin
      // restoring step: one quotient bit per cycle
      if (rem_sh >= {1'b0, dmag}) begin
        rem      <= CH_W'(rem_sh - {1'b0, dmag});
        quotient <= {quotient[ACC_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[CH_W-1:0];
        quotient <= {quotient[ACC_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hdl/rwc_regs.sv
module rwc_regs import rwc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [1:0] index;

  assign pready = 1'b1;
  assign index  = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_top    <= KERNEL_TOP_RESET;
      cfg.kernel_middle <= KERNEL_MIDDLE_RESET;
      cfg.kernel_bottom <= KERNEL_BOTTOM_RESET;
      cfg.scale         <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      case (index)
        REG_KERNEL_TOP:    cfg.kernel_top    <= pwdata[PIX_W-1:0];
        REG_KERNEL_MIDDLE: cfg.kernel_middle <= pwdata[PIX_W-1:0];
        REG_KERNEL_BOTTOM: cfg.kernel_bottom <= pwdata[PIX_W-1:0];
        REG_SCALE:         cfg.scale         <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_KERNEL_TOP:    prdata = DATA_W'(cfg.kernel_top);
      REG_KERNEL_MIDDLE: prdata = DATA_W'(cfg.kernel_middle);
      REG_KERNEL_BOTTOM: prdata = DATA_W'(cfg.kernel_bottom);
      REG_SCALE:         prdata = DATA_W'(cfg.scale);
      default:           prdata = '0;
    endcase
  end

endmodule

>>> hdl/rgb_window_convolution_core.sv
// 3x3 convolution over a stream of packed 24-bit RGB pixels. Each pixel pushes into a
// window of WINDOW_DEPTH pixels kept as a ring in one single-port-write, registered-read
// RAM; taps sit at row*LINE_WIDTH+col from the oldest pixel and windows wrap across line
// ends. Each channel sum is divided by the signed scale (zero acts as one), truncated
// toward zero and clamped to 0..255. Each item passes through the states in order: S_IDLE
// accepts it, S_TAP walks the nine taps through the RAM read port, S_LAST ends the last
// multiply-accumulate, S_START starts the dividers and S_DIV runs the one-bit-per-cycle
// restoring divide; the next item is accepted while the last result waits for a taker.
// No clearing pass is needed after reset: a fill count marks window slots not yet
// written, and they read as zero.
module rgb_window_convolution_core import rwc_pkg::*; #(
  parameter int KERNEL_SIZE  = 3,
  parameter int LINE_WIDTH   = 512,
  parameter int WINDOW_DEPTH = 1027
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  rwc_pix_in_if.sink          pixels,
  rwc_pix_out_if.source       filtered
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int CW = $clog2(2 * LINE_WIDTH + 2 * WINDOW_DEPTH + 4);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAP   = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  cfg_t cfg;

  rwc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [2:0]  state;
  logic [1:0]  row;
  logic [1:0]  col;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] newest;
  logic [FW-1:0] fill;
  logic          accept;

  // sideband held for the whole transaction
  logic       sb_last;
  logic [3:0] sb_keep;
  logic [3:0] sb_strobe;
  logic       sb_user;
  logic       sb_ident;
  logic       sb_route;

  assign pixels.ready = (state == S_IDLE);
  assign accept       = pixels.valid && pixels.ready;

  // tap address: slot k lives at newest+1+k, modulo the depth
  logic [CW-1:0] tap_idx;
  logic [CW-1:0] tap_sum;
  logic [AW-1:0] tap_addr;
  logic          tap_ok;
  logic [PIX_W-1:0] row_word;
  logic signed [CH_W-1:0] tap_w;

  always_comb begin
    tap_idx = CW'(row) * CW'(LINE_WIDTH) + CW'(col);
    tap_sum = CW'(newest) + CW'(1) + tap_idx;
    if (tap_sum >= CW'(WINDOW_DEPTH)) begin
      tap_sum = tap_sum - CW'(WINDOW_DEPTH);
    end
    tap_addr = tap_sum[AW-1:0];
    tap_ok = (32'(row) < KERNEL_SIZE) && (32'(col) < KERNEL_SIZE)
             && (tap_idx < CW'(WINDOW_DEPTH))
             && (tap_idx + CW'(fill) >= CW'(WINDOW_DEPTH));
    case (row)
      2'd0:    row_word = cfg.kernel_top;
      2'd1:    row_word = cfg.kernel_middle;
      2'd2:    row_word = cfg.kernel_bottom;
      default: row_word = '0;
    endcase
    tap_w = row_word[8 * col +: CH_W];
  end

  logic [PIX_W-1:0] rd_data;

  rwc_ram #(.WIDTH(PIX_W), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_ptr),
    .wdata (pixels.in_pixel),
    .raddr (tap_addr),
    .rdata (rd_data)
  );

  // multiply-accumulate stage, in the cycle after the tap read
  logic                   mac_en;
  logic                   mac_ok;
  logic signed [CH_W-1:0] mac_w;
  logic signed [ACC_W-1:0] acc [NUM_CH];

  // divider handshake and results
  logic [NUM_CH-1:0] div_done;
  logic [NUM_CH-1:0] div_neg;
  logic [ACC_W-1:0]  div_q [NUM_CH];
  logic [PIX_W-1:0]  result;

  always_ff @(posedge clk) begin
    mac_ok <= tap_ok;
    mac_w  <= tap_w;
    if (accept) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        acc[ch] <= '0;
      end
    end else if (mac_en && mac_ok) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        acc[ch] <= acc[ch] + ACC_W'($signed({1'b0, rd_data[8 * ch +: CH_W]}))
                   * ACC_W'(mac_w);
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      row    <= '0;
      col    <= '0;
      wr_ptr <= '0;
      newest <= '0;
      fill   <= '0;
      mac_en <= 1'b0;
    end else begin
      mac_en <= (state == S_TAP);
      case (state)
        S_IDLE: begin
          if (accept) begin
            newest <= wr_ptr;
            wr_ptr <= (32'(wr_ptr) == WINDOW_DEPTH - 1) ? '0 : wr_ptr + AW'(1);
            if (32'(fill) != WINDOW_DEPTH) begin
              fill <= fill + FW'(1);
            end
            row   <= '0;
            col   <= '0;
            state <= S_TAP;
          end
        end
        S_TAP: begin
          if (col == 2'd2) begin
            col <= '0;
            row <= row + 2'd1;
            if (row == 2'd2) begin
              state <= S_LAST;
            end
          end else begin
            col <= col + 2'd1;
          end
        end
        S_LAST:  state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (div_done == '1 && (!filtered.valid || filtered.ready)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sb_last   <= pixels.in_last;
      sb_keep   <= pixels.in_keep;
      sb_strobe <= pixels.in_strobe;
      sb_user   <= pixels.in_user;
      sb_ident  <= pixels.in_ident;
      sb_route  <= pixels.in_route;
    end
  end

  // one divider per channel, all started together
  for (genvar g = 0; g < NUM_CH; g++) begin : g_div
    rwc_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (state == S_START),
      .dividend (acc[g]),
      .divisor  (cfg.scale),
      .done     (div_done[g]),
      .neg      (div_neg[g]),
      .quotient (div_q[g])
    );
  end

  // clamp: a negative quotient drops to zero, anything above the channel max saturates
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (div_neg[ch]) begin
        result[8 * ch +: CH_W] = '0;
      end else if (div_q[ch] > ACC_W'(CHANNEL_MAX)) begin
        result[8 * ch +: CH_W] = CHANNEL_MAX;
      end else begin
        result[8 * ch +: CH_W] = div_q[ch][CH_W-1:0];
      end
    end
  end

  // output register: hold the result until the transaction completes
  logic load_out;
  assign load_out = (state == S_DIV) && (div_done == '1)
                    && (!filtered.valid || filtered.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered.valid <= 1'b0;
    end else if (load_out) begin
      filtered.valid <= 1'b1;
    end else if (filtered.ready) begin
      filtered.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      filtered.out_pixel  <= result;
      filtered.out_last   <= sb_last;
      filtered.out_keep   <= sb_keep;
      filtered.out_strobe <= sb_strobe;
      filtered.out_user   <= sb_user;
      filtered.out_ident  <= sb_ident;
      filtered.out_route  <= sb_route;
    end
  end

endmodule

>>> tb/rgb_window_convolution_core_tb.sv
module rgb_window_convolution_core_tb import rwc_pkg::*;;

  localparam int LINE_WIDTH   = 512;
  localparam int WINDOW_DEPTH = 1027;
  localparam int KERNEL_SIZE  = 3;
  // settle time after the last result: one item's pass through the core plus slack
  localparam int CORE_LATENCY = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic [3:0]       keep;
    logic [3:0]       strobe;
    logic             user;
    logic             ident;
    logic             route;
  } beat_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  rwc_pix_in_if  pix_in ();
  rwc_pix_out_if pix_out ();

  rgb_window_convolution_core #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .LINE_WIDTH  (LINE_WIDTH),
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pix_in),
    .filtered(pix_out)
  );

  // Shadow copy of the core: pixel window (slot 0 oldest) and the four registers.
  logic [PIX_W-1:0] window_pixels [WINDOW_DEPTH];
  logic [PIX_W-1:0] kernel_rows [3];
  logic [CH_W-1:0]  scale_reg;

  beat_t expected_beats [$];
  int    mismatch_count;
  int    cycle_count;

  // Sender burst state and receiver stall state.
  int burst_left;
  int hold_left;
  int stall_mode;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run as failed once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: hold off for long stretches on request, otherwise stall on a
  // pattern that switches between always ready, random and periodic.
  always @(negedge clk) begin
    if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_left > 0) begin
      pix_out.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      case (stall_mode)
        0: pix_out.ready <= 1'b1;
        1: pix_out.ready <= ($urandom_range(0, 3) != 0);
        default: pix_out.ready <= (cycle_count % 7) > 2;
      endcase
    end
  end

  // Advance the shadow window by one pixel and compute the filtered beat.
  function automatic beat_t filter_pixel(beat_t in_beat);
    beat_t res;
    int    acc [3];
    int    divisor;
    int    quot;
    int    tap;
    int    slot;
    logic [PIX_W-1:0] px;
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) window_pixels[i] = window_pixels[i + 1];
    window_pixels[WINDOW_DEPTH - 1] = in_beat.pixel;
    for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
    for (int r = 0; r < KERNEL_SIZE && r < 3; r++) begin
      for (int c = 0; c < KERNEL_SIZE && c < 3; c++) begin
        slot = r * LINE_WIDTH + c;
        px = (slot < WINDOW_DEPTH) ? window_pixels[slot] : '0;
        tap = $signed(kernel_rows[r][8*c +: 8]);
        for (int ch = 0; ch < 3; ch++) acc[ch] += int'(px[8*ch +: 8]) * tap;
      end
    end
    divisor = $signed(scale_reg);
    if (divisor == 0) divisor = 1;
    res = in_beat;
    for (int ch = 0; ch < 3; ch++) begin
      quot = acc[ch] / divisor;   // truncates toward zero
      if (quot > 255) res.pixel[8*ch +: 8] = CHANNEL_MAX;
      else if (quot < 0) res.pixel[8*ch +: 8] = '0;
      else res.pixel[8*ch +: 8] = quot[7:0];
    end
    return res;
  endfunction

  // Checker: compare each output transaction against the oldest expectation.
  always @(posedge clk) begin
    beat_t want;
    beat_t got;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = '{pix_out.out_pixel, pix_out.out_last, pix_out.out_keep, pix_out.out_strobe,
              pix_out.out_user, pix_out.out_ident, pix_out.out_route};
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected output transaction %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // APB write: setup cycle, then access cycle; the register takes it at the
  // edge that closes the access cycle.
  task automatic write_reg(logic [1:0] index, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({index, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (index)
      REG_KERNEL_TOP:    kernel_rows[0] = value[PIX_W-1:0];
      REG_KERNEL_MIDDLE: kernel_rows[1] = value[PIX_W-1:0];
      REG_KERNEL_BOTTOM: kernel_rows[2] = value[PIX_W-1:0];
      REG_SCALE:         scale_reg = value[CH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for every expected result, then let the core settle.
  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (CORE_LATENCY) @(posedge clk);
  endtask

  // Load a full setting; upper bits of the bus word are random junk.
  task automatic load_kernel(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
                             logic [PIX_W-1:0] bot, logic [CH_W-1:0] scale);
    wait_drained();
    write_reg(REG_KERNEL_TOP,    {8'($urandom()), top});
    write_reg(REG_KERNEL_MIDDLE, {8'($urandom()), mid});
    write_reg(REG_KERNEL_BOTTOM, {8'($urandom()), bot});
    write_reg(REG_SCALE,         {24'($urandom()), scale});
  endtask

  // Send one input transaction, inserting a random gap at the start of each burst.
  task automatic send_beat(beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        pix_in.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    pix_in.valid     <= 1'b1;
    pix_in.in_pixel  <= b.pixel;
    pix_in.in_last   <= b.last;
    pix_in.in_keep   <= b.keep;
    pix_in.in_strobe <= b.strobe;
    pix_in.in_user   <= b.user;
    pix_in.in_ident  <= b.ident;
    pix_in.in_route  <= b.route;
    do @(posedge clk); while (!pix_in.ready);
    expected_beats.push_back(filter_pixel(b));
  endtask

  // Drop valid once a stretch of traffic is done.
  task automatic idle_sender();
    @(negedge clk);
    pix_in.valid <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b.pixel  = {pick_channel(), pick_channel(), pick_channel()};
    b.last   = 1'($urandom());
    b.keep   = 4'($urandom());
    b.strobe = 4'($urandom());
    b.user   = 1'($urandom());
    b.ident  = 1'($urandom());
    b.route  = 1'($urandom());
    return b;
  endfunction

  // Taps in a narrow signed range so sums often land inside 0..255.
  function automatic logic [PIX_W-1:0] mild_row();
    logic [PIX_W-1:0] row;
    for (int c = 0; c < 3; c++) row[8*c +: 8] = 8'($signed($urandom_range(0, 8)) - 4);
    return row;
  endfunction

  // Reset setting is the identity on the center tap: check pass-through of
  // the delayed pixel and every sideband extreme while the window is still zero.
  task automatic test_identity_extremes();
    beat_t b;
    b = '{24'h000000, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0};
    send_beat(b);
    b = '{24'hFFFFFF, 1'b1, 4'hF, 4'hF, 1'b1, 1'b1, 1'b1};
    send_beat(b);
    b = '{24'h800000, 1'b0, 4'hA, 4'h5, 1'b1, 1'b0, 1'b1};
    send_beat(b);
    b = '{24'h008001, 1'b1, 4'h5, 4'hA, 1'b0, 1'b1, 1'b0};
    send_beat(b);
    b = '{24'h7F7F7F, 1'b0, 4'h1, 4'h8, 1'b1, 1'b1, 1'b0};
    send_beat(b);
    idle_sender();
  endtask

  // Saturating kernels, negative kernels and each divisor extreme, including zero.
  task automatic test_kernel_extremes();
    load_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'h00);
    repeat (4) send_beat(random_beat());
    idle_sender();
    load_kernel(24'h808080, 24'h808080, 24'h808080, 8'h80);
    repeat (4) send_beat(random_beat());
    idle_sender();
    load_kernel(24'h010101, 24'h010101, 24'h010101, 8'h7F);
    repeat (4) send_beat(random_beat());
    idle_sender();
    load_kernel(24'h000000, 24'h00FF00, 24'h000000, 8'hFF);
    repeat (4) send_beat(random_beat());
    idle_sender();
  endtask

  // Long random stream across several settings; the window fills and wraps
  // across line ends, so every tap eventually reads live pixels.
  task automatic test_random_stream(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 3))
        0: load_kernel(24'($urandom()), 24'($urandom()), 24'($urandom()), 8'($urandom()));
        1: load_kernel(mild_row(), mild_row(), mild_row(), 8'($urandom_range(0, 16)));
        2: load_kernel(24'h010101, 24'h010101, 24'h010101, 8'd9);
        default: load_kernel(mild_row(), mild_row(), mild_row(), 8'(-$urandom_range(1, 8)));
      endcase
      repeat (per_phase) send_beat(random_beat());
      idle_sender();
    end
  endtask

  // Hold the receiver off while the sender keeps offering, so the core
  // backs up and stalls its input.
  task automatic test_output_backpressure();
    wait_drained();
    hold_left = 400;
    repeat (30) send_beat(random_beat());
    idle_sender();
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_sender_pause();
    repeat (20) send_beat(random_beat());
    idle_sender();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) send_beat(random_beat());
    idle_sender();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_in.valid = 1'b0;
    pix_in.in_pixel = '0;
    pix_in.in_last = 1'b0;
    pix_in.in_keep = '0;
    pix_in.in_strobe = '0;
    pix_in.in_user = 1'b0;
    pix_in.in_ident = 1'b0;
    pix_in.in_route = 1'b0;
    pix_out.ready = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    hold_left = 0;
    stall_mode = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++) window_pixels[i] = '0;
    kernel_rows[0] = KERNEL_TOP_RESET;
    kernel_rows[1] = KERNEL_MIDDLE_RESET;
    kernel_rows[2] = KERNEL_BOTTOM_RESET;
    scale_reg = SCALE_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_identity_extremes();
    test_kernel_extremes();
    test_random_stream(4, 300);
    test_output_backpressure();
    test_random_stream(3, 150);
    test_sender_pause();
    test_random_stream(1, 110);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/rwc_pkg.sv
hdl/rwc_pix_in_if.sv
hdl/rwc_pix_out_if.sv
hdl/rwc_ram.sv
hdl/rwc_div.sv
hdl/rwc_regs.sv
hdl/rgb_window_convolution_core.sv
tb/rgb_window_convolution_core_tb.sv
